/* hw/rtl/kdlp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlp_pkg
// Types and register codes shared by the key debounce / long-press block.
// ----------------------------------------------------------------------------
package kdlp_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned MS_W       = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ON            = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_LEN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_REPEAT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_ENABLE = 3'd4;

  localparam logic [CNT_W-1:0] SETTLE_LEN_RST = 8'd3;

  typedef struct packed {
    logic             key_on;
    logic [CNT_W-1:0] settle_len;
    logic [MS_W-1:0]  long_press_ms;
    logic             long_press_repeat;
    logic             long_press_enable;
  } cfg_t;

  typedef struct packed {
    logic            sample_level;
    logic [MS_W-1:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic rising_event;
    logic falling_event;
    logic long_press_event;
    logic stable_out;
    logic raw_out;
  } out_item_t;

endpackage

/* hw/rtl/kdlp_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlp_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface kdlp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/key_debounce_edge_long_press.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_edge_long_press
// Debounced key with rising, falling and long-press events.
// ----------------------------------------------------------------------------
// One result beat per sample beat. A sample is taken into an input register,
// processed against the debounce state once the output register is free and
// written to it, so a new sample is accepted every cycle unless the output
// handshake stalls. Elapsed press time is computed modulo 2^TIME_WIDTH. The
// user must see that registers are written through the cfg_ port only while
// no sample is in flight; the block itself does not enforce this.
module key_debounce_edge_long_press
  import kdlp_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  kdlp_stream_if.sink           in_s,
  kdlp_stream_if.source         out_s,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg_r;
  logic      in_valid_r;
  in_item_t  in_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t result;
  logic      advance;

  assign advance    = in_valid_r && (!out_valid_r || out_s.ready);
  assign in_s.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_on            <= 1'b1;
      cfg_r.settle_len        <= SETTLE_LEN_RST;
      cfg_r.long_press_ms     <= '0;
      cfg_r.long_press_repeat <= 1'b0;
      cfg_r.long_press_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_ON:            cfg_r.key_on            <= cfg_wdata[0];
        CFG_SETTLE_LEN:        cfg_r.settle_len        <= cfg_wdata[CNT_W-1:0];
        CFG_LONG_PRESS_MS:     cfg_r.long_press_ms     <= cfg_wdata[MS_W-1:0];
        CFG_LONG_PRESS_REPEAT: cfg_r.long_press_repeat <= cfg_wdata[0];
        CFG_LONG_PRESS_ENABLE: cfg_r.long_press_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_s.ready) begin
      in_valid_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      in_data_r <= in_s.data;
    end
  end

  kdlp_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .cfg    (cfg_r),
    .item   (in_data_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_s.valid = out_valid_r;
  assign out_s.data  = out_data_r;

endmodule

/* hw/rtl/kdlp_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlp_core
// Debounce, edge and long-press state with its single-step update.
// ----------------------------------------------------------------------------
module kdlp_core
  import kdlp_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  cfg_t      cfg,
  input  in_item_t  item,
  output out_item_t result
);

  logic                  raw_r, raw_nxt;
  logic                  stable_r, stable_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [TIME_WIDTH-1:0] start_r, start_nxt;
  logic                  done_r, done_nxt;

  logic [63:0]           now_ext, lim_ext;
  logic [TIME_WIDTH-1:0] now, lim, elapsed;
  logic [CNT_W-1:0]      cnt_inc;
  logic                  rise, fall, lp, reached;

  assign now_ext = {32'd0, item.time_ms};
  assign lim_ext = {32'd0, cfg.long_press_ms};
  assign now     = now_ext[TIME_WIDTH-1:0];
  assign lim     = lim_ext[TIME_WIDTH-1:0];
  assign cnt_inc = cnt_r + 8'd1;

  always_comb begin
    raw_nxt    = raw_r;
    stable_nxt = stable_r;
    cnt_nxt    = cnt_r;
    start_nxt  = start_r;
    done_nxt   = done_r;
    rise       = 1'b0;
    fall       = 1'b0;
    lp         = 1'b0;
    if (cfg.key_on) begin
      raw_nxt = item.sample_level;
      if (item.sample_level == stable_r) begin
        cnt_nxt = '0;
      end else if (cnt_inc >= cfg.settle_len) begin
        stable_nxt = item.sample_level;
        cnt_nxt    = '0;
        rise       = item.sample_level;
        fall       = ~item.sample_level;
        if (item.sample_level) begin
          start_nxt = now;
          done_nxt  = 1'b0;
        end
      end else begin
        cnt_nxt = cnt_inc;
      end
    end
    elapsed = now - start_nxt;
    reached = (elapsed >= lim);
    if (cfg.key_on && stable_nxt && cfg.long_press_enable) begin
      if (cfg.long_press_repeat) begin
        lp = reached;
      end else if (!done_nxt && reached) begin
        lp       = 1'b1;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 1'b0;
      stable_r <= 1'b0;
      cnt_r    <= '0;
      start_r  <= '0;
      done_r   <= 1'b0;
    end else if (step) begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      cnt_r    <= cnt_nxt;
      start_r  <= start_nxt;
      done_r   <= done_nxt;
    end
  end

  always_comb begin
    result.rising_event     = rise;
    result.falling_event    = fall;
    result.long_press_event = lp;
    result.stable_out       = stable_nxt;
    result.raw_out          = raw_nxt;
  end

endmodule

/* hw/rtl/kdlp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlp_checker
// Port-level checks on the result channel of the key debounce block.
// ----------------------------------------------------------------------------
module kdlp_checker
  import kdlp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_edge_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.rising_event && out_data.falling_event))
    else $error("rising and falling in one beat");

  a_rise_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.rising_event) |-> out_data.stable_out)
    else $error("rising event with low stable level");

  a_fall_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.falling_event) |-> !out_data.stable_out)
    else $error("falling event with high stable level");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result beat changed while stalled");

endmodule

bind key_debounce_edge_long_press kdlp_checker u_kdlp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_s.valid),
  .out_ready (out_s.ready),
  .out_data  (out_s.data)
);

/* tb/tb_key_debounce_edge_long_press.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_debounce_edge_long_press
// Self-checking bench for the debounced key with edge and long-press events.
// A cycle-free model of the debounce state runs alongside the block and
// predicts each result beat from every sample beat taken at the input. Stimulus
// is a short directed part followed by random press/release sequences with
// chatter and time wrap, over several register settings, with random gaps on
// both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_key_debounce_edge_long_press;
  import kdlp_pkg::*;

  class key_event_tracker;
    logic             key_on;
    logic [CNT_W-1:0] settle_len;
    logic [MS_W-1:0]  long_press_ms;
    logic             long_press_repeat;
    logic             long_press_enable;

    logic             raw_level;
    logic             stable_level;
    logic [CNT_W-1:0] debounce_count;
    logic [MS_W-1:0]  press_start_ms;
    logic             long_press_done;

    out_item_t        expected_events[$];
    int unsigned      error_count;

    function new();
      key_on             = 1'b1;
      settle_len         = SETTLE_LEN_RST;
      long_press_ms      = '0;
      long_press_repeat  = 1'b0;
      long_press_enable  = 1'b0;
      raw_level          = 1'b0;
      stable_level       = 1'b0;
      debounce_count     = '0;
      press_start_ms     = '0;
      long_press_done    = 1'b0;
      error_count        = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_KEY_ON:             key_on             = val[0];
        CFG_SETTLE_LEN:         settle_len         = val[CNT_W-1:0];
        CFG_LONG_PRESS_MS:      long_press_ms      = val[MS_W-1:0];
        CFG_LONG_PRESS_REPEAT:  long_press_repeat  = val[0];
        CFG_LONG_PRESS_ENABLE:  long_press_enable  = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_events.size();
    endfunction

    function void note_sample(in_item_t s);
      out_item_t      r;
      logic [MS_W-1:0] elapsed;
      r = '0;
      if (key_on) begin
        raw_level = s.sample_level;
        if (s.sample_level == stable_level) begin
          debounce_count = '0;
        end else begin
          debounce_count = debounce_count + 1'b1;
          if (debounce_count >= settle_len) begin
            stable_level   = s.sample_level;
            debounce_count = '0;
            if (stable_level) begin
              r.rising_event  = 1'b1;
              press_start_ms  = s.time_ms;
              long_press_done = 1'b0;
            end else begin
              r.falling_event = 1'b1;
            end
          end
        end
        if (stable_level && long_press_enable) begin
          elapsed = s.time_ms - press_start_ms;
          if (elapsed >= long_press_ms) begin
            if (long_press_repeat) begin
              r.long_press_event = 1'b1;
            end else if (!long_press_done) begin
              r.long_press_event = 1'b1;
              long_press_done    = 1'b1;
            end
          end
        end
      end
      r.stable_out = stable_level;
      r.raw_out    = raw_level;
      expected_events.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
    endtask

    task compare_field(string name, logic got, logic want);
      if (got !== want)
        report_mismatch($sformatf("%s got %b expected %b", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_events.size() == 0) begin
        report_mismatch("result beat with no sample pending");
      end else begin
        want = expected_events.pop_front();
        compare_field("rising_event",     got.rising_event,     want.rising_event);
        compare_field("falling_event",    got.falling_event,    want.falling_event);
        compare_field("long_press_event", got.long_press_event, want.long_press_event);
        compare_field("stable_out",       got.stable_out,       want.stable_out);
        compare_field("raw_out",          got.raw_out,          want.raw_out);
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  kdlp_stream_if #(.payload_t(in_item_t))  in_ch ();
  kdlp_stream_if #(.payload_t(out_item_t)) out_ch ();

  key_event_tracker tracker;
  bit               no_gaps;
  bit               hold_request;
  int unsigned      sent_count;
  logic [MS_W-1:0]  clock_ms;

  key_debounce_edge_long_press DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_ch),
    .out_s     (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) tracker.note_sample(in_ch.data);
      if (out_ch.valid && out_ch.ready) tracker.check_result(out_ch.data);
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 200;
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (no_gaps) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 31);
      end
    end
  end

  function automatic logic [MS_W-1:0] next_time();
    if ($urandom_range(19) == 0) clock_ms = clock_ms + $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 40);
    return clock_ms;
  endfunction

  task automatic send_sample(input logic lvl, input logic [MS_W-1:0] t);
    in_item_t beat;
    beat.sample_level = lvl;
    beat.time_ms      = t;
    while (!no_gaps && $urandom_range(99) < 31) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= beat;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(input logic en, input logic [CNT_W-1:0] thr,
                               input logic [MS_W-1:0] lp_ms, input logic rep,
                               input logic lp_en);
    drain();
    write_reg(CFG_KEY_ON, CFG_DATA_W'(en));
    write_reg(CFG_SETTLE_LEN, CFG_DATA_W'(thr));
    write_reg(CFG_LONG_PRESS_MS, CFG_DATA_W'(lp_ms));
    write_reg(CFG_LONG_PRESS_REPEAT, CFG_DATA_W'(rep));
    write_reg(CFG_LONG_PRESS_ENABLE, CFG_DATA_W'(lp_en));
    cfg_we <= 1'b0;
  endtask

  // chatter, a held press, chatter, then a held release
  task automatic press_cycle(input int unsigned thr);
    int unsigned k;
    int unsigned hold;
    int unsigned rel;
    k    = $urandom_range(0, 3);
    hold = thr + $urandom_range(0, 25);
    rel  = thr + $urandom_range(0, 8);
    repeat (k) begin
      send_sample(1'b1, next_time());
      send_sample(1'b0, next_time());
    end
    repeat (hold) send_sample(1'b1, next_time());
    k = $urandom_range(0, 3);
    repeat (k) begin
      send_sample(1'b0, next_time());
      send_sample(1'b1, next_time());
    end
    repeat (rel) send_sample(1'b0, next_time());
  endtask

  task automatic run_phase(input int unsigned target, input int unsigned thr);
    while (sent_count < target) begin
      if ($urandom_range(99) < 80) begin
        press_cycle(thr);
      end else begin
        repeat ($urandom_range(1, 4)) send_sample(1'($urandom_range(1)), $urandom);
      end
    end
  endtask

  initial begin
    int unsigned thr;
    logic [MS_W-1:0] lp_ms;
    tracker      = new();
    no_gaps      = 1'b0;
    hold_request = 1'b0;
    sent_count   = 0;
    clock_ms     = '0;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero threshold, largest limit reached only one ms short of a full wrap
    apply_setting(1'b1, 8'd0, 32'hFFFF_FFFF, 1'b0, 1'b1);
    send_sample(1'b1, 32'hFFFF_FFF0);
    send_sample(1'b1, 32'hFFFF_FFEF);
    send_sample(1'b1, 32'hFFFF_FFEF);
    send_sample(1'b0, 32'h0000_0000);
    send_sample(1'b0, 32'hFFFF_FFFF);

    // repeat mode with zero limit, chatter ahead of the press
    apply_setting(1'b1, 8'd3, 32'd0, 1'b1, 1'b1);
    send_sample(1'b1, 32'd0);
    send_sample(1'b0, 32'd5);
    send_sample(1'b1, 32'd6);
    send_sample(1'b1, 32'd7);
    send_sample(1'b1, 32'd8);
    send_sample(1'b1, 32'd9);
    send_sample(1'b0, 32'd10);
    send_sample(1'b0, 32'd11);
    send_sample(1'b0, 32'd12);
    send_sample(1'b0, 32'd13);

    // key disabled: state held, no events
    apply_setting(1'b0, 8'd2, 32'd10, 1'b0, 1'b1);
    send_sample(1'b1, 32'd1);
    send_sample(1'b1, 32'd2);
    send_sample(1'b1, 32'd3);

    // largest threshold, across the time wrap
    apply_setting(1'b1, 8'd255, 32'd50, 1'b0, 1'b1);
    clock_ms = 32'hFFFF_FF00;
    press_cycle(255);

    for (int p = 1; p <= 8; p++) begin
      thr = $urandom_range(0, 6);
      case ($urandom_range(3))
        0:       lp_ms = '0;
        1:       lp_ms = $urandom_range(1, 300);
        2:       lp_ms = $urandom_range(300, 1500);
        default: lp_ms = $urandom;
      endcase
      apply_setting((p == 1) ? 1'b0 : 1'b1, thr[CNT_W-1:0], lp_ms,
                    1'($urandom_range(1)), ($urandom_range(3) != 0));
      no_gaps  = (p == 2);
      clock_ms = $urandom_range(1) ? $urandom : 32'hFFFF_FFC0;
      if (p == 3) hold_request = 1'b1;
      run_phase(sent_count + $urandom_range(20, 40), thr);
    end

    drain();
    repeat (8) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("%0d expected beats never arrived", tracker.pending()));
    if (tracker.error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
